// ===== rtl/pid_position_controller_macros.svh =====
`ifndef PID_POSITION_CONTROLLER_MACROS_SVH
`define PID_POSITION_CONTROLLER_MACROS_SVH

// same-cycle implication, checked out of reset
`define PPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ppc_pkg.sv =====
package ppc_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int FIFO_DEPTH_DEF     = 4;

  localparam int DATA_W   = 16;
  localparam int GAIN_W   = 24;
  localparam int LIMIT_W  = 20;
  localparam int ERR_W    = 17;
  localparam int INTEG_W  = 21;
  localparam int DERIV_W  = 6;
  localparam int CFG_IDX_W = 4;

  localparam int DERIV_ABS_MAX = 30;
  localparam int DTERM_CUTOFF  = 2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P          = 4'd0,
    CFG_GAIN_I          = 4'd1,
    CFG_GAIN_D          = 4'd2,
    CFG_SETPOINT        = 4'd3,
    CFG_INTEGRATE_BELOW = 4'd4,
    CFG_INTEGRAL_LIMIT  = 4'd5,
    CFG_DRIVE_MIN       = 4'd6,
    CFG_DRIVE_MAX       = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [DATA_W-1:0]  setpoint;
    logic [DATA_W-1:0]  integrate_below;
    logic [LIMIT_W-1:0] integral_abs_limit;
    logic [DATA_W-1:0]  drive_min;
    logic [DATA_W-1:0]  drive_max;
  } cfg_t;

  // terms handed from the front to the back
  typedef struct packed {
    logic [ERR_W-1:0]   err;
    logic [INTEG_W-1:0] integ;
    logic [DERIV_W-1:0] deriv;
  } term_t;

endpackage

// ===== rtl/pid_position_controller.sv =====
// Channel  | Dir | Word                            | Handshake
// s_axis   | in  | tdata: sample_value, tuser: ok  | tvalid/tready
// m_axis   | out | tdata: drive                    | tvalid/tready
// cfg      | in  | cfg_idx_i selects, cfg_wdata_i  | cfg_we_i, no wait
//
// One word accepted per cycle while the queue has room; the result then passes
// through the queue, multiply, scale, sum and clamp stages, in that order.
// The error/integral/derivative front runs in the accept cycle; its state
// update is the only word-to-word dependency.
// Reset clears state, valid bits and config to defaults; no clearing pass.
// A stalled output freezes the back pipeline; the front keeps taking words
// until the queue is full.
module pid_position_controller import ppc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int FIFO_DEPTH     = FIFO_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [DATA_W-1:0]    s_axis_tdata_i,  // [15:0] sample_value
  input  logic                 s_axis_tuser_i,  // [0] sample_ok
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [DATA_W-1:0]    m_axis_tdata_o,  // [15:0] drive
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GAIN_W-1:0]    cfg_wdata_i
);

  cfg_t  cfg_q;
  term_t push_term, pop_term;
  logic  push, pop, q_ready, q_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p             <= '0;
      cfg_q.gain_i             <= '0;
      cfg_q.gain_d             <= '0;
      cfg_q.setpoint           <= '0;
      cfg_q.integrate_below    <= '0;
      cfg_q.integral_abs_limit <= '0;
      cfg_q.drive_min          <= 16'h8000;
      cfg_q.drive_max          <= 16'h7fff;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_P:          cfg_q.gain_p <= cfg_wdata_i;
        CFG_GAIN_I:          cfg_q.gain_i <= cfg_wdata_i;
        CFG_GAIN_D:          cfg_q.gain_d <= cfg_wdata_i;
        CFG_SETPOINT:        cfg_q.setpoint <= cfg_wdata_i[DATA_W-1:0];
        CFG_INTEGRATE_BELOW: cfg_q.integrate_below <= cfg_wdata_i[DATA_W-1:0];
        CFG_INTEGRAL_LIMIT:  cfg_q.integral_abs_limit <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_DRIVE_MIN:       cfg_q.drive_min <= cfg_wdata_i[DATA_W-1:0];
        CFG_DRIVE_MAX:       cfg_q.drive_max <= cfg_wdata_i[DATA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ppc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sample_value_i  (s_axis_tdata_i),
    .sample_ok_i     (s_axis_tuser_i),
    .q_ready_i       (q_ready),
    .push_o          (push),
    .term_o          (push_term)
  );

  ppc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_term),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_term)
  );

  ppc_back #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .q_data_i        (pop_term),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ===== rtl/ppc_front.sv =====
`include "pid_position_controller_macros.svh"

module ppc_front import ppc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [DATA_W-1:0] sample_value_i,
  input  logic              sample_ok_i,
  input  logic              q_ready_i,
  output logic              push_o,
  output term_t             term_o
);

  logic signed [ERR_W-1:0]   prev_error_q, prev_error_d;
  logic signed [INTEG_W-1:0] integral_q, integral_d;

  logic signed [ERR_W-1:0]   diff;
  logic        [ERR_W-1:0]   abs_err;
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W:0]   lim;
  logic signed [INTEG_W:0]   iclamp;
  logic signed [ERR_W:0]     dsum;

  assign s_axis_tready_o = q_ready_i;
  assign push_o          = s_axis_tvalid_i & q_ready_i;

  always_comb begin
    diff    = $signed({cfg_i.setpoint[DATA_W-1], cfg_i.setpoint})
            - $signed({sample_value_i[DATA_W-1], sample_value_i});
    abs_err = diff[ERR_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
    isum    = integral_q + diff;
    lim     = $signed({2'b00, cfg_i.integral_abs_limit});
    if (isum > lim) begin
      iclamp = lim;
    end else if (isum < -lim) begin
      iclamp = -lim;
    end else begin
      iclamp = isum;
    end
    dsum = diff - prev_error_q;

    prev_error_d = '0;
    integral_d   = '0;
    term_o.deriv = '0;
    if (sample_ok_i) begin
      prev_error_d = diff;
      if (abs_err < {1'b0, cfg_i.integrate_below}) begin
        integral_d = INTEG_W'(iclamp);
      end
      // derivative spikes are dropped
      if (!(dsum > DERIV_ABS_MAX || dsum < -DERIV_ABS_MAX)) begin
        term_o.deriv = DERIV_W'(dsum);
      end
    end
    term_o.err   = prev_error_d;
    term_o.integ = integral_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_error_q <= '0;
      integral_q   <= '0;
    end else if (push_o) begin
      prev_error_q <= prev_error_d;
      integral_q   <= integral_d;
    end
  end

  `PPC_ASSERT_NEXT(a_invalid_clears, push_o && !sample_ok_i, prev_error_q == '0 && integral_q == '0, "invalid word must clear state")

endmodule

// ===== rtl/ppc_fifo.sv =====
`include "pid_position_controller_macros.svh"

module ppc_fifo import ppc_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  term_t push_data_i,
  output logic  ready_o,
  input  logic  pop_i,
  output logic  valid_o,
  output term_t pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  term_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;

  assign ready_o    = cnt_q != CNT_W'(DEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `PPC_ASSERT_SAME(a_no_pop_empty, pop_i, cnt_q != '0, "pop from empty queue")
  `PPC_ASSERT_NEXT(a_cnt_up, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "count lost a push")

endmodule

// ===== rtl/ppc_back.sv =====
`include "pid_position_controller_macros.svh"

module ppc_back import ppc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              q_valid_i,
  input  term_t             q_data_i,
  output logic              pop_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DATA_W-1:0] m_axis_tdata_o
);

  localparam int WIDE_W = 48;
  localparam int TP_W   = GAIN_W + 1 + ERR_W;
  localparam int TI_W   = GAIN_W + 1 + INTEG_W;
  localparam int TD_W   = GAIN_W + 1 + DERIV_W;
  localparam int SUM_W  = TI_W + 2;
  localparam logic signed [WIDE_W-1:0] FRAC_MASK =
    (48'sd1 <<< GAIN_FRAC_BITS) - 48'sd1;

  // divide by 2^frac, rounding toward zero
  function automatic logic signed [WIDE_W-1:0] scale_down(
    input logic signed [WIDE_W-1:0] x
  );
    logic signed [WIDE_W-1:0] bias;
    bias = x[WIDE_W-1] ? FRAC_MASK : '0;
    return (x + bias) >>> GAIN_FRAC_BITS;
  endfunction

  // below min wins over above max; with inverted limits the result is min or max, never x
  function automatic logic signed [DATA_W-1:0] clamp_drive(
    input logic signed [WIDE_W-1:0] x,
    input logic signed [DATA_W-1:0] lo,
    input logic signed [DATA_W-1:0] hi
  );
    logic signed [DATA_W-1:0] r;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  logic signed [DATA_W-1:0] dmin, dmax;
  logic                     adv;

  logic                     v1_q, v2_q, v3_q, v4_q;
  logic signed [TP_W-1:0]   pp_q, tp_q;
  logic signed [TI_W-1:0]   pi_q, ti_q;
  logic signed [TD_W-1:0]   pd_q, td_q;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [DATA_W-1:0] drive_q;

  logic signed [TP_W-1:0]   pp_d;
  logic signed [TI_W-1:0]   pi_d;
  logic signed [TD_W-1:0]   pd_d;
  logic signed [DATA_W-1:0] ti_c;
  logic signed [TD_W-1:0]   td_k;

  assign dmin  = $signed(cfg_i.drive_min);
  assign dmax  = $signed(cfg_i.drive_max);
  assign adv   = !v4_q || m_axis_tready_i;
  assign pop_o = adv && q_valid_i;

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = drive_q;

  always_comb begin
    pp_d  = $signed({1'b0, cfg_i.gain_p}) * $signed(q_data_i.err);
    pi_d  = $signed({1'b0, cfg_i.gain_i}) * $signed(q_data_i.integ);
    pd_d  = $signed({1'b0, cfg_i.gain_d}) * $signed(q_data_i.deriv);
    ti_c  = clamp_drive(WIDE_W'(ti_q), dmin, dmax);
    // only a large positive derivative term is cut off
    td_k  = (td_q >= DTERM_CUTOFF) ? '0 : td_q;
    sum_d = tp_q + ti_c + td_k;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_q    <= pp_d;
      pi_q    <= pi_d;
      pd_q    <= pd_d;
      tp_q    <= TP_W'(scale_down(WIDE_W'(pp_q)));
      ti_q    <= TI_W'(scale_down(WIDE_W'(pi_q)));
      td_q    <= TD_W'(scale_down(WIDE_W'(pd_q)));
      sum_q   <= sum_d;
      drive_q <= clamp_drive(WIDE_W'(sum_q), dmin, dmax);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= q_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  `PPC_ASSERT_SAME(a_drive_in_range, v4_q && dmin <= dmax, drive_q >= dmin && drive_q <= dmax, "drive outside limits")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ppc_pkg::*;

  localparam int GAIN_FRAC        = GAIN_FRAC_BITS_DEF;
  localparam int FIRST_UNUSED_IDX = CFG_DRIVE_MAX + 1;
  localparam int NUM_PHASES       = 20;
  localparam int WORDS_PER_PHASE  = 55;
  localparam int HOLD_CYCLES      = 64;
  localparam int SETTLE_CYCLES    = 20;
  localparam int IDLE_LIMIT       = 3000;

  typedef enum logic {
    STEP_WRITE,
    STEP_WORD
  } step_kind_e;

  typedef struct {
    step_kind_e         kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [GAIN_W-1:0]  wdata;
    logic [DATA_W-1:0]  sample;
    logic               ok;
    bit                 has_ref;
    logic [DATA_W-1:0]  ref_drive;
  } plan_step_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic [DATA_W-1:0]    s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [GAIN_W-1:0]    cfg_wdata = '0;
  wire                  s_tready;
  wire                  m_tvalid;
  wire  [DATA_W-1:0]    m_tdata;

  pid_position_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [15:0] sample_value
    .s_axis_tuser_i  (s_tuser),   // [0] sample_ok
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [15:0] drive
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // controller settings and state as the block should hold them
  logic [GAIN_W-1:0]        kp, ki, kd;
  logic signed [DATA_W-1:0] set_pt;
  logic [DATA_W-1:0]        integ_thresh;
  logic [LIMIT_W-1:0]       integ_limit;
  logic signed [DATA_W-1:0] out_min, out_max;
  logic signed [ERR_W-1:0]  prev_err;
  logic signed [INTEG_W-1:0] err_sum;

  logic [DATA_W-1:0] pending_drive[$];
  plan_step_t        plan[$];

  int  mismatches = 0;
  int  words_sent = 0;
  int  drives_seen = 0;
  int  settings_applied = 0;
  int  holds_done = 0;
  int  burst_left = 0;
  bit  hold_req = 1'b0;

  function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    case (idx)
      CFG_GAIN_P:          kp = data;
      CFG_GAIN_I:          ki = data;
      CFG_GAIN_D:          kd = data;
      CFG_SETPOINT:        set_pt = data[DATA_W-1:0];
      CFG_INTEGRATE_BELOW: integ_thresh = data[DATA_W-1:0];
      CFG_INTEGRAL_LIMIT:  integ_limit = data[LIMIT_W-1:0];
      CFG_DRIVE_MIN:       out_min = data[DATA_W-1:0];
      CFG_DRIVE_MAX:       out_max = data[DATA_W-1:0];
      default: ;
    endcase
  endfunction

  // Q16.8 gain times term, truncated toward zero
  function automatic longint gain_scale(logic [GAIN_W-1:0] g, longint t);
    return (longint'(g) * t) / (longint'(1) << GAIN_FRAC);
  endfunction

  // below the minimum wins over above the maximum when the limits are inverted
  function automatic longint fit_drive(longint v);
    if (v < longint'(out_min)) return longint'(out_min);
    if (v > longint'(out_max)) return longint'(out_max);
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] next_drive(logic signed [DATA_W-1:0] sample, logic ok);
    longint e, ae, ig, dv, tp, ti, td;
    e  = 0;
    ig = 0;
    dv = 0;
    if (ok) begin
      e  = longint'(set_pt) - longint'(sample);
      ae = (e < 0) ? -e : e;
      if (ae < longint'(integ_thresh)) begin
        ig = longint'(err_sum) + e;
        if (ig > longint'(integ_limit)) ig = longint'(integ_limit);
        else if (ig < -longint'(integ_limit)) ig = -longint'(integ_limit);
      end
      dv = e - longint'(prev_err);
      if (dv > DERIV_ABS_MAX || dv < -DERIV_ABS_MAX) dv = 0;
    end
    prev_err = e[ERR_W-1:0];
    err_sum  = ig[INTEG_W-1:0];
    tp = gain_scale(kp, e);
    ti = fit_drive(gain_scale(ki, ig));
    td = gain_scale(kd, dv);
    if (td >= DTERM_CUTOFF) td = 0;
    return DATA_W'(fit_drive(tp + ti + td));
  endfunction

  // mostly inside [lo, hi], now and then one of the two extremes
  function automatic longint pick_value(longint lo, longint hi, longint ext_lo, longint ext_hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return ext_lo;
    if (r == 1) return ext_hi;
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    plan_step_t s;
    s.kind = STEP_WRITE;
    s.idx = idx;
    s.wdata = data;
    s.sample = '0;
    s.ok = 1'b0;
    s.has_ref = 1'b0;
    s.ref_drive = '0;
    plan.push_back(s);
  endfunction

  function automatic void add_word(logic [DATA_W-1:0] sample, logic ok, bit has_ref,
                                   logic [DATA_W-1:0] ref_drive);
    plan_step_t s;
    s.kind = STEP_WORD;
    s.idx = '0;
    s.wdata = '0;
    s.sample = sample;
    s.ok = ok;
    s.has_ref = has_ref;
    s.ref_drive = ref_drive;
    plan.push_back(s);
  endfunction

  // wait until every drive has come back, with the input side quiet
  task automatic drain();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_drive.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    apply_setting(idx, data);
  endtask

  task automatic send_word(input logic [DATA_W-1:0] sample, input logic ok,
                           input bit has_ref, input logic [DATA_W-1:0] ref_drive);
    int gap;
    logic [DATA_W-1:0] d;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    s_tuser  <= ok;
    do @(posedge clk_i); while (!s_tready);
    burst_left--;
    words_sent++;
    d = next_drive(sample, ok);
    pending_drive.push_back(has_ref ? ref_drive : d);
  endtask

  // output side: stall pattern of its own, plus long hold-offs on request
  initial begin : receiver
    int  mode, mode_left, hold_left;
    bit  rdy;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(0, 1) == 1);
          default: rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      m_tready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      drives_seen++;
      if (pending_drive.size() == 0) begin
        mismatches++;
        $display("%0t: drive with none outstanding, expected none, got %0d",
                 $time, $signed(m_tdata));
      end else if (m_tdata !== pending_drive[0]) begin
        mismatches++;
        $display("%0t: drive mismatch, expected %0d, got %0d",
                 $time, $signed(pending_drive[0]), $signed(m_tdata));
        void'(pending_drive.pop_front());
      end else begin
        void'(pending_drive.pop_front());
      end
    end
  end

  // ends the run when nothing moves on either side for too long
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    longint vals[8];
    logic [GAIN_W-1:0] mask;
    longint cur;
    bit tracking;
    logic [DATA_W-1:0] smp;
    logic ok;

    kp = '0;
    ki = '0;
    kd = '0;
    set_pt = '0;
    integ_thresh = '0;
    integ_limit = '0;
    out_min = 16'sh8000;
    out_max = 16'sh7FFF;
    prev_err = '0;
    err_sum = '0;

    // reset defaults: no gain, so the drive is zero
    add_word(16'h0000, 1'b1, 1'b1, 16'h0000);
    add_word(16'h8000, 1'b1, 1'b1, 16'h0000);
    add_word(16'h7FFF, 1'b0, 1'b1, 16'h0000);
    // unity P gain, output saturates at the top
    add_write(CFG_GAIN_P, 24'h000100);
    add_word(16'h8000, 1'b1, 1'b1, 16'h7FFF);
    add_word(16'h7FFF, 1'b1, 1'b1, -16'sd32767);
    add_word(16'd100, 1'b0, 1'b1, 16'h0000);
    // largest gain and widest error
    add_write(CFG_GAIN_P, 24'hFFFFFF);
    add_write(CFG_SETPOINT, 24'h007FFF);
    add_word(16'h8000, 1'b1, 1'b1, 16'h7FFF);
    add_word(16'h7FFF, 1'b1, 1'b1, 16'h0000);
    add_write(CFG_SETPOINT, 24'h008000);
    add_word(16'h7FFF, 1'b1, 1'b1, 16'h8000);
    // integral only: accumulate, clamp, leave the window, invalid sample
    add_write(CFG_GAIN_P, 24'h000000);
    add_write(CFG_GAIN_I, 24'h000100);
    add_write(CFG_SETPOINT, 24'h000000);
    add_write(CFG_INTEGRATE_BELOW, 24'd100);
    add_write(CFG_INTEGRAL_LIMIT, 24'd150);
    add_word(-16'sd50, 1'b1, 1'b1, 16'd50);
    add_word(-16'sd50, 1'b1, 1'b1, 16'd100);
    add_word(-16'sd50, 1'b1, 1'b1, 16'd150);
    add_word(-16'sd50, 1'b1, 1'b1, 16'd150);
    add_word(-16'sd100, 1'b1, 1'b1, 16'd0);
    add_word(16'd60, 1'b1, 1'b1, -16'sd60);
    add_word(16'd60, 1'b0, 1'b1, 16'd0);
    // zero integral limit
    add_write(CFG_INTEGRAL_LIMIT, 24'd0);
    add_word(-16'sd10, 1'b1, 1'b1, 16'd0);
    // derivative at the +/-DERIV_ABS_MAX edge, above it, and the term cutoff
    add_write(CFG_GAIN_I, 24'h000000);
    add_write(CFG_GAIN_D, 24'd25600);
    add_word(-16'sd40, 1'b1, 1'b0, '0);
    add_word(-16'sd10, 1'b1, 1'b0, '0);
    add_word(-16'sd50, 1'b1, 1'b0, '0);
    add_word(-16'sd69, 1'b1, 1'b0, '0);
    // inverted limits: a zero sample is expected to give the upper clamp
    add_write(CFG_GAIN_D, 24'h000000);
    add_write(CFG_DRIVE_MIN, 24'd100);
    add_write(CFG_DRIVE_MAX, 24'h00FF9C);
    add_word(16'd0, 1'b0, 1'b1, -16'sd100);
    add_word(16'd0, 1'b1, 1'b1, -16'sd100);
    // writes past the last register change nothing
    add_write(CFG_DRIVE_MIN, 24'h008000);
    add_write(CFG_DRIVE_MAX, 24'h007FFF);
    add_write(CFG_GAIN_P, 24'h000100);
    for (int i = FIRST_UNUSED_IDX; i < (1 << CFG_IDX_W); i++)
      add_write(CFG_IDX_W'(i), 24'h000000);
    add_word(16'h8000, 1'b1, 1'b1, 16'h7FFF);
    add_word(16'h7FFF, 1'b1, 1'b1, -16'sd32767);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        drain();
        cfg_write(plan[i].idx, plan[i].wdata);
        settings_applied++;
      end else begin
        send_word(plan[i].sample, plan[i].ok, plan[i].has_ref, plan[i].ref_drive);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      tracking = (ph % 4 != 0);
      if (tracking) begin
        vals[CFG_GAIN_P]          = pick_value(0, 2048, 0, 24'hFFFFFF);
        vals[CFG_GAIN_I]          = pick_value(0, 512, 0, 24'hFFFFFF);
        vals[CFG_GAIN_D]          = pick_value(0, 40000, 0, 24'hFFFFFF);
        vals[CFG_SETPOINT]        = pick_value(-30000, 30000, -32768, 32767);
        vals[CFG_INTEGRATE_BELOW] = pick_value(0, 300, 0, 65535);
        vals[CFG_INTEGRAL_LIMIT]  = pick_value(0, 6000, 0, 20'hFFFFF);
        vals[CFG_DRIVE_MIN]       = pick_value(-32768, -500, -32768, 32767);
        vals[CFG_DRIVE_MAX]       = pick_value(500, 32767, -32768, 32767);
      end else begin
        vals[CFG_GAIN_P]          = pick_value(0, 24'hFFFFFF, 0, 24'hFFFFFF);
        vals[CFG_GAIN_I]          = pick_value(0, 24'hFFFFFF, 0, 24'hFFFFFF);
        vals[CFG_GAIN_D]          = pick_value(0, 24'hFFFFFF, 0, 24'hFFFFFF);
        vals[CFG_SETPOINT]        = pick_value(-32768, 32767, -32768, 32767);
        vals[CFG_INTEGRATE_BELOW] = pick_value(0, 65535, 0, 65535);
        vals[CFG_INTEGRAL_LIMIT]  = pick_value(0, 20'hFFFFF, 0, 20'hFFFFF);
        vals[CFG_DRIVE_MIN]       = pick_value(-32768, 32767, -32768, 32767);
        vals[CFG_DRIVE_MAX]       = pick_value(-32768, 32767, -32768, 32767);
      end
      drain();
      for (int i = CFG_GAIN_P; i <= CFG_DRIVE_MAX; i++) begin
        case (i)
          CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D: mask = 24'hFFFFFF;
          CFG_INTEGRAL_LIMIT:                 mask = 24'h0FFFFF;
          default:                            mask = 24'h00FFFF;
        endcase
        // junk above the register width must be dropped
        cfg_write(CFG_IDX_W'(i), (GAIN_W'(vals[i]) & mask) | (GAIN_W'($urandom) & ~mask));
      end
      if ($urandom_range(0, 3) == 0)
        cfg_write(CFG_IDX_W'(FIRST_UNUSED_IDX + $urandom_range(0, 7)), GAIN_W'($urandom));
      settings_applied++;

      if (ph == 3 || ph == 12) hold_req = 1'b1;

      cur = longint'(set_pt) + $urandom_range(0, 100) - 50;
      for (int w = 0; w < WORDS_PER_PHASE; w++) begin
        if (tracking) begin
          // slow walk around the setpoint so the integral and derivative paths engage
          if ($urandom_range(0, 39) == 0) cur = longint'(set_pt) + $urandom_range(0, 2000) - 1000;
          else cur = cur + $urandom_range(0, 30) - 15;
          if (cur > 32767) cur = 32767;
          if (cur < -32768) cur = -32768;
          smp = cur[DATA_W-1:0];
          ok = ($urandom_range(0, 19) != 0);
        end else begin
          smp = DATA_W'($urandom);
          ok = ($urandom_range(0, 4) != 0);
        end
        send_word(smp, ok, 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d samples across %0d register settings, %0d drives compared.",
             words_sent, settings_applied, drives_seen);
    $display("Covered integral window and clamp, derivative cutoff, inverted limits, %0d holds.",
             holds_done);
    if (mismatches == 0 && pending_drive.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
